FILE: hdl/dnsf_pkg.sv
// Shared definitions for the DNS A-record response framer: opcodes,
// sequencer phases, frame constants and the fixed-byte lookup functions.
// Used by dns_a_response_framer; no dependencies of its own.
package dnsf_pkg;

  // Longest label kept; longer labels are truncated and flag an error.
  localparam int LABEL_MAX_DEF = 63;

  localparam int OP_W    = 2;
  localparam int CH_W    = 8;
  localparam int ID_W    = 16;
  localparam int IP_W    = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 2;

  // Input tdata layout, lowest bit first: ch, query_id, ip_addr, no_answer.
  localparam int IN_DATA_W  = 64;
  localparam int CH_LSB     = 0;
  localparam int ID_LSB     = CH_LSB + CH_W;
  localparam int IP_LSB     = ID_LSB + ID_W;
  localparam int NA_LSB     = IP_LSB + IP_W;
  // Output tdata layout, lowest bit first: byte_first, byte_second, byte_count.
  localparam int OUT_DATA_W = 24;

  localparam logic [CH_W-1:0] CH_DOT = 8'h2E;

  localparam logic [15:0] DNS_FLAGS    = 16'h8180;
  localparam logic [15:0] NAME_PTR     = 16'hC00C;
  localparam logic [15:0] RR_TYPE_A    = 16'h0001;
  localparam logic [15:0] RR_CLASS_IN  = 16'h0001;
  localparam logic [31:0] RR_TTL       = 32'd300;
  localparam logic [15:0] RR_RDLENGTH  = 16'd4;

  localparam int HDR_LAST     = 11;  // header is 12 bytes
  localparam int TAIL_LAST_NA = 4;   // terminator, type, class
  localparam int TAIL_LAST    = 20;  // plus the 16-byte answer

  localparam logic [CNT_W-1:0] COUNT_ONE = 2'd1;
  localparam logic [CNT_W-1:0] COUNT_TWO = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_LBL  = 5'b01000,
    PH_TAIL = 5'b10000
  } phase_t;

  // Header byte at a given offset.
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [3:0] idx,
                                                 input logic [ID_W-1:0] id,
                                                 input logic na);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = DNS_FLAGS[15:8];
      4'd3:    b = DNS_FLAGS[7:0];
      4'd5:    b = 8'h01;              // one question
      4'd7:    b = {7'b0, ~na};        // answer count
      default: b = '0;
    endcase
    return b;
  endfunction

  // Byte after the last label: terminator, question type/class, answer.
  function automatic logic [BYTE_W-1:0] tail_byte(input logic [4:0] idx,
                                                  input logic [IP_W-1:0] ip);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (idx)
      5'd0:    b = 8'h00;
      5'd1:    b = RR_TYPE_A[15:8];
      5'd2:    b = RR_TYPE_A[7:0];
      5'd3:    b = RR_CLASS_IN[15:8];
      5'd4:    b = RR_CLASS_IN[7:0];
      5'd5:    b = NAME_PTR[15:8];
      5'd6:    b = NAME_PTR[7:0];
      5'd7:    b = RR_TYPE_A[15:8];
      5'd8:    b = RR_TYPE_A[7:0];
      5'd9:    b = RR_CLASS_IN[15:8];
      5'd10:   b = RR_CLASS_IN[7:0];
      5'd11:   b = RR_TTL[31:24];
      5'd12:   b = RR_TTL[23:16];
      5'd13:   b = RR_TTL[15:8];
      5'd14:   b = RR_TTL[7:0];
      5'd15:   b = RR_RDLENGTH[15:8];
      5'd16:   b = RR_RDLENGTH[7:0];
      5'd17:   b = ip[31:24];
      5'd18:   b = ip[23:16];
      5'd19:   b = ip[15:8];
      5'd20:   b = ip[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/dnsf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; read data holds while rd_en is low.
module dnsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/dns_a_response_framer.sv
// Top level of the DNS A-record response framer: input decode, label
// buffer control, byte sequencer, byte pairing and output register.
// Depends on dnsf_pkg and dnsf_ram.
//
//  Channel | Ports       | Payload
//  --------+-------------+---------------------------------------------------
//  input   | in_t*       | tuser: op; tdata: ch, query_id, ip_addr, no_answer
//  result  | out_t*      | tdata: byte_first, byte_second, byte_count;
//          |             | tuser: run_last, frame_error; tlast: frame_last
//
// A character item emits no bytes. An item that emits bytes walks them out
// one byte per cycle, while the output is not stalled, through a two-stage
// pipe (sequencer, then the label RAM read or a fixed byte): the header for
// a start, the length byte and the label for a dot, and the length byte,
// label and tail for an end. The single read port of the label RAM sets the
// byte rate. Reset is synchronous and active low; the RAM needs no clearing.
// A stalled output holds the pipe; input is taken again once every byte of
// the previous item has left the pairing stage, even while the last result
// still waits in the output register.
module dns_a_response_framer #(
  parameter int LABEL_MAX = dnsf_pkg::LABEL_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] ch, [23:8] query_id, [55:24] ip_addr, [56] no_answer, rest zero
  input  logic [dnsf_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [dnsf_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] byte_first, [15:8] byte_second, [17:16] byte_count, rest zero
  output logic [dnsf_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] run_last, [1] frame_error
  output logic [1:0]                      out_tuser,
  // frame_last
  output logic                            out_tlast
);

  import dnsf_pkg::*;

  // Label RAM addressing and fill count.
  localparam int AW   = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int FW   = $clog2(LABEL_MAX + 1);
  // The sequencer counter covers the header, a label and the tail.
  localparam int CMAX = (LABEL_MAX > TAIL_LAST + 1) ? LABEL_MAX : TAIL_LAST + 1;
  localparam int CW   = $clog2(CMAX + 1);

  // Input field unpacking.
  op_t               in_op;
  logic [CH_W-1:0]   in_ch;
  logic [ID_W-1:0]   in_id;
  logic [IP_W-1:0]   in_ip;
  logic              in_na;

  assign in_op = op_t'(in_tuser);
  assign in_ch = in_tdata[CH_LSB +: CH_W];
  assign in_id = in_tdata[ID_LSB +: ID_W];
  assign in_ip = in_tdata[IP_LSB +: IP_W];
  assign in_na = in_tdata[NA_LSB];

  // Frame context.
  logic [ID_W-1:0] id_r, id_nxt;
  logic [IP_W-1:0] ip_r, ip_nxt;
  logic            na_r, na_nxt;
  logic            in_frame_r, in_frame_nxt;
  logic            ovf_r, ovf_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;

  // Sequencer stage.
  phase_t          ph_r, ph_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [FW-1:0]   len_r, len_nxt;
  logic            end_r, end_nxt;   // item is the end of the domain
  logic            err_r, err_nxt;   // overflow latched for the end item

  // Byte stage: RAM read data or a fixed byte.
  logic              bv_r, bv_nxt;
  logic              b_mem_r, b_mem_nxt;
  logic [BYTE_W-1:0] b_const_r, b_const_nxt;
  logic              b_last_r, b_last_nxt;
  logic              b_frame_r, b_frame_nxt;

  // Pairing stage.
  logic              hv_r, hv_nxt;
  logic [BYTE_W-1:0] h_byte_r, h_byte_nxt;

  // Output register.
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] o_first_r, o_first_nxt;
  logic [BYTE_W-1:0] o_second_r, o_second_nxt;
  logic [CNT_W-1:0]  o_count_r, o_count_nxt;
  logic              o_run_last_r, o_run_last_nxt;
  logic              o_frame_last_r, o_frame_last_nxt;
  logic              o_error_r, o_error_nxt;

  logic              in_acc;
  logic              busy;
  logic              out_free;
  logic              b_take;
  logic              a_go;
  logic [BYTE_W-1:0] a_byte;
  logic              a_mem;
  logic              a_last;
  phase_t            ph_adv;
  logic [CW-1:0]     cnt_adv;
  logic [CW-1:0]     tail_last;
  logic [BYTE_W-1:0] b_byte;
  logic              b_fin;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;

  // The RAM is only written while no flush is in flight, so reads and
  // writes of the label never overlap.
  assign busy      = (ph_r != PH_IDLE) || bv_r || hv_r;
  assign in_tready = ~busy;
  assign in_acc    = in_tvalid & in_tready;

  assign ram_wr_en = in_acc && (in_op == OP_CHAR) && in_frame_r && (in_ch != CH_DOT) &&
                     (fill_r < FW'(LABEL_MAX));

  assign out_free = ~ov_r | out_tready;
  assign b_byte   = b_mem_r ? ram_rd_data : b_const_r;
  // A byte leaves the byte stage into the half register freely; completing
  // a result needs room in the output register.
  assign b_take   = bv_r && ((hv_r || b_last_r) ? out_free : 1'b1);
  assign a_go     = (ph_r != PH_IDLE) && (~bv_r || b_take);
  assign b_fin    = b_last_r & b_frame_r;

  assign tail_last = na_r ? CW'(TAIL_LAST_NA) : CW'(TAIL_LAST);

  // Byte selection and phase advance of the sequencer.
  always_comb begin
    a_byte  = '0;
    a_mem   = 1'b0;
    a_last  = 1'b0;
    ph_adv  = ph_r;
    cnt_adv = cnt_r + 1'b1;
    case (ph_r)
      PH_HDR: begin
        a_byte = hdr_byte(cnt_r[3:0], id_r, na_r);
        if (cnt_r == CW'(HDR_LAST)) begin
          a_last = 1'b1;
          ph_adv = PH_IDLE;
        end
      end
      PH_LEN: begin
        a_byte  = BYTE_W'(len_r);
        cnt_adv = '0;
        if (len_r == '0) begin
          if (end_r) begin
            ph_adv = PH_TAIL;
          end else begin
            a_last = 1'b1;
            ph_adv = PH_IDLE;
          end
        end else begin
          ph_adv = PH_LBL;
        end
      end
      PH_LBL: begin
        a_mem = 1'b1;
        if (cnt_r + 1'b1 == CW'(len_r)) begin
          cnt_adv = '0;
          if (end_r) begin
            ph_adv = PH_TAIL;
          end else begin
            a_last = 1'b1;
            ph_adv = PH_IDLE;
          end
        end
      end
      PH_TAIL: begin
        a_byte = tail_byte(cnt_r[4:0], ip_r);
        if (cnt_r == tail_last) begin
          a_last = 1'b1;
          ph_adv = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_rd_en = a_go & a_mem;

  // Next-state logic for all stages.
  always_comb begin
    id_nxt       = id_r;
    ip_nxt       = ip_r;
    na_nxt       = na_r;
    in_frame_nxt = in_frame_r;
    ovf_nxt      = ovf_r;
    fill_nxt     = fill_r;
    ph_nxt       = ph_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    err_nxt      = err_r;

    if (in_acc) begin
      case (in_op)
        OP_START: begin
          // A start inside an open frame simply abandons it.
          id_nxt       = in_id;
          ip_nxt       = in_ip;
          na_nxt       = in_na;
          fill_nxt     = '0;
          ovf_nxt      = 1'b0;
          in_frame_nxt = 1'b1;
          ph_nxt       = PH_HDR;
          cnt_nxt      = '0;
          end_nxt      = 1'b0;
        end
        OP_CHAR: begin
          if (in_frame_r) begin
            if (in_ch == CH_DOT) begin
              len_nxt  = fill_r;
              fill_nxt = '0;
              ph_nxt   = PH_LEN;
              end_nxt  = 1'b0;
            end else if (fill_r >= FW'(LABEL_MAX)) begin
              ovf_nxt = 1'b1;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        OP_END: begin
          if (in_frame_r) begin
            len_nxt      = fill_r;
            fill_nxt     = '0;
            ph_nxt       = PH_LEN;
            end_nxt      = 1'b1;
            err_nxt      = ovf_r;
            ovf_nxt      = 1'b0;
            in_frame_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (a_go) begin
      ph_nxt  = ph_adv;
      cnt_nxt = cnt_adv;
    end

    // Byte stage.
    bv_nxt      = bv_r;
    b_mem_nxt   = b_mem_r;
    b_const_nxt = b_const_r;
    b_last_nxt  = b_last_r;
    b_frame_nxt = b_frame_r;
    if (a_go) begin
      bv_nxt      = 1'b1;
      b_mem_nxt   = a_mem;
      b_const_nxt = a_byte;
      b_last_nxt  = a_last;
      b_frame_nxt = end_r;
    end else if (b_take) begin
      bv_nxt = 1'b0;
    end

    // Pairing and output register.
    hv_nxt           = hv_r;
    h_byte_nxt       = h_byte_r;
    ov_nxt           = ov_r & ~out_tready;
    o_first_nxt      = o_first_r;
    o_second_nxt     = o_second_r;
    o_count_nxt      = o_count_r;
    o_run_last_nxt   = o_run_last_r;
    o_frame_last_nxt = o_frame_last_r;
    o_error_nxt      = o_error_r;
    if (b_take) begin
      if (hv_r) begin
        hv_nxt           = 1'b0;
        ov_nxt           = 1'b1;
        o_first_nxt      = h_byte_r;
        o_second_nxt     = b_byte;
        o_count_nxt      = COUNT_TWO;
        o_run_last_nxt   = b_last_r;
        o_frame_last_nxt = b_fin;
        o_error_nxt      = b_fin & err_r;
      end else if (b_last_r) begin
        ov_nxt           = 1'b1;
        o_first_nxt      = b_byte;
        o_second_nxt     = '0;
        o_count_nxt      = COUNT_ONE;
        o_run_last_nxt   = 1'b1;
        o_frame_last_nxt = b_fin;
        o_error_nxt      = b_fin & err_r;
      end else begin
        hv_nxt     = 1'b1;
        h_byte_nxt = b_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      ovf_r      <= 1'b0;
      fill_r     <= '0;
      ph_r       <= PH_IDLE;
      cnt_r      <= '0;
      bv_r       <= 1'b0;
      hv_r       <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      ovf_r      <= ovf_nxt;
      fill_r     <= fill_nxt;
      ph_r       <= ph_nxt;
      cnt_r      <= cnt_nxt;
      bv_r       <= bv_nxt;
      hv_r       <= hv_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r           <= id_nxt;
    ip_r           <= ip_nxt;
    na_r           <= na_nxt;
    len_r          <= len_nxt;
    end_r          <= end_nxt;
    err_r          <= err_nxt;
    b_mem_r        <= b_mem_nxt;
    b_const_r      <= b_const_nxt;
    b_last_r       <= b_last_nxt;
    b_frame_r      <= b_frame_nxt;
    h_byte_r       <= h_byte_nxt;
    o_first_r      <= o_first_nxt;
    o_second_r     <= o_second_nxt;
    o_count_r      <= o_count_nxt;
    o_run_last_r   <= o_run_last_nxt;
    o_frame_last_r <= o_frame_last_nxt;
    o_error_r      <= o_error_nxt;
  end

  dnsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LABEL_MAX),
    .AW    (AW)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_ch),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*BYTE_W - CNT_W){1'b0}}, o_count_r, o_second_r,
                       o_first_r};
  assign out_tuser  = {o_error_r, o_run_last_r};
  assign out_tlast  = o_frame_last_r;

endmodule

FILE: tb/tb_dns_a_response_framer.sv
// Self-checking testbench for dns_a_response_framer: drives query items,
// predicts the byte pairs of each DNS response frame, and checks every result.
// Depends on dnsf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_dns_a_response_framer;
  import dnsf_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] first_b;
    logic [BYTE_W-1:0] second_b;
    logic [CNT_W-1:0]  count;
    logic              run_last;
    logic              frame_last;
    logic              frame_error;
  } frame_pair_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] ch, [23:8] id, [55:24] ip, [56] no_answer
  logic [OP_W-1:0]       in_tuser;   // [1:0] op
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] first, [15:8] second, [17:16] count
  logic [1:0]            out_tuser;  // [0] run_last, [1] frame_error
  logic                  out_tlast;  // frame_last

  dns_a_response_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Byte pairs that the framer still owes, oldest first.
  frame_pair_t pairs_due[$];
  int          errors;
  int          useful_items;
  bit          tx_idle_on;
  bit          rx_stall_on;

  // Shadow of the framer's state, kept by the predictor.
  logic [BYTE_W-1:0] label_bytes [64];
  logic [6:0]        label_len;
  logic              label_overrun;
  logic [ID_W-1:0]   resp_id;
  logic [IP_W-1:0]   resp_ip;
  logic              resp_no_ans;
  logic              frame_open;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the byte pairs that one accepted item produces and queues them.
  // Returns 0 when the framer simply ignores the item.
  function automatic bit predict_response(op_t op, logic [CH_W-1:0] ch,
                                          logic [ID_W-1:0] id, logic [IP_W-1:0] ip,
                                          logic na);
    logic [BYTE_W-1:0] seq[$];
    frame_pair_t       p;
    bit                closes;
    int                pos;
    closes = 1'b0;
    if (op == OP_START) begin
      resp_id       = id;
      resp_ip       = ip;
      resp_no_ans   = na;
      label_len     = '0;
      label_overrun = 1'b0;
      frame_open    = 1'b1;
      seq = '{id[15:8], id[7:0], DNS_FLAGS[15:8], DNS_FLAGS[7:0], 8'h00, 8'h01,
              8'h00, {7'b0, ~na}, 8'h00, 8'h00, 8'h00, 8'h00};
    end else if (op == OP_RSVD || !frame_open) begin
      return 1'b0;
    end else if (op == OP_CHAR && ch != CH_DOT) begin
      // Characters past the longest label are dropped but remembered.
      if (label_len >= LABEL_MAX_DEF) begin
        label_overrun = 1'b1;
      end else begin
        label_bytes[label_len[5:0]] = ch;
        label_len++;
      end
      return 1'b1;
    end else begin
      // A dot or the end item flushes the label held so far.
      seq.push_back({1'b0, label_len});
      for (int i = 0; i < label_len; i++) seq.push_back(label_bytes[i[5:0]]);
      label_len = '0;
      if (op == OP_END) begin
        seq.push_back(8'h00);
        seq.push_back(RR_TYPE_A[15:8]);
        seq.push_back(RR_TYPE_A[7:0]);
        seq.push_back(RR_CLASS_IN[15:8]);
        seq.push_back(RR_CLASS_IN[7:0]);
        if (!resp_no_ans) begin
          seq.push_back(NAME_PTR[15:8]);
          seq.push_back(NAME_PTR[7:0]);
          seq.push_back(RR_TYPE_A[15:8]);
          seq.push_back(RR_TYPE_A[7:0]);
          seq.push_back(RR_CLASS_IN[15:8]);
          seq.push_back(RR_CLASS_IN[7:0]);
          seq.push_back(RR_TTL[31:24]);
          seq.push_back(RR_TTL[23:16]);
          seq.push_back(RR_TTL[15:8]);
          seq.push_back(RR_TTL[7:0]);
          seq.push_back(RR_RDLENGTH[15:8]);
          seq.push_back(RR_RDLENGTH[7:0]);
          seq.push_back(resp_ip[31:24]);
          seq.push_back(resp_ip[23:16]);
          seq.push_back(resp_ip[15:8]);
          seq.push_back(resp_ip[7:0]);
        end
        closes = 1'b1;
      end
    end
    // Pair the bytes up; an odd byte goes out alone at the end of the run.
    pos = 0;
    while (pos < seq.size()) begin
      p.first_b     = seq[pos];
      p.count       = (seq.size() - pos >= 2) ? COUNT_TWO : COUNT_ONE;
      p.second_b    = (p.count == COUNT_TWO) ? seq[pos+1] : 8'h00;
      pos          += p.count;
      p.run_last    = (pos >= seq.size());
      p.frame_last  = p.run_last && closes;
      p.frame_error = p.run_last && closes && label_overrun;
      pairs_due.push_back(p);
    end
    if (closes) begin
      frame_open    = 1'b0;
      label_overrun = 1'b0;
    end
    return 1'b1;
  endfunction

  // Sends one item, with a random idle burst ahead of it when idling is on.
  // tvalid stays high between back-to-back items.
  task automatic send_item(op_t op, logic [CH_W-1:0] ch = '0, logic [ID_W-1:0] id = '0,
                           logic [IP_W-1:0] ip = '0, logic na = 1'b0);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, na, ip, id, ch};
    do @(posedge clk); while (!in_tready);
    if (predict_response(op, ch, id, ip, na)) useful_items++;
  endtask

  task automatic send_chars(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
  endtask

  // Holds the sender off until every owed result has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pairs_due.size() != 0);
  endtask

  function automatic logic [CH_W-1:0] pick_char();
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyz0123456789-";
    if ($urandom_range(0, 3) != 0) return alphabet[$urandom_range(0, alphabet.len() - 1)];
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Characters and end items before any start must be dropped silently.
  task automatic test_outside_frame();
    send_item(OP_CHAR, "a");
    send_item(OP_END);
    send_item(OP_RSVD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_CHAR, CH_DOT);
    wait_drained();
  endtask

  // All-zero and all-one ids and addresses, with and without the answer.
  task automatic test_header_extremes();
    send_item(OP_START, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
    send_item(OP_END);
    send_item(OP_START, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_chars("x");
    send_item(OP_END);
    wait_drained();
  endtask

  // Empty labels from doubled and trailing dots, NUL and 0xFF characters,
  // and a reserved op in the middle of a frame.
  task automatic test_label_forms();
    send_item(OP_START, 8'h00, 16'h1234, 32'hC0A8_0001, 1'b0);
    send_item(OP_CHAR, CH_DOT);
    send_item(OP_CHAR, CH_DOT);
    send_chars("ab");
    send_item(OP_CHAR, 8'h00);
    send_item(OP_RSVD, "q");
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, CH_DOT);
    send_item(OP_END);
    wait_drained();
  endtask

  // A start inside an open frame abandons it, then a stray end follows.
  task automatic test_restart_in_frame();
    send_item(OP_START, 8'h00, 16'hBEEF, 32'h0A00_0001, 1'b0);
    send_chars("xy");
    send_item(OP_START, 8'h00, 16'h00FF, 32'h0102_0304, 1'b1);
    send_chars("z");
    send_item(OP_END);
    send_item(OP_END);
    wait_drained();
  endtask

  // A label past the limit is cut to its maximum and flags the frame.
  task automatic test_overlong_label();
    send_item(OP_START, 8'h00, 16'h5A5A, 32'h7F00_0001, 1'b0);
    repeat (LABEL_MAX_DEF + 3) send_item(OP_CHAR, CH_W'("a" + $urandom_range(0, 25)));
    send_item(OP_END);
    // The next frame must come out clean again.
    send_item(OP_START, 8'h00, 16'hA5A5, 32'h0808_0808, 1'b0);
    send_chars("ok");
    send_item(OP_END);
    wait_drained();
  endtask

  // One random response frame: mostly well-formed, sometimes abandoned.
  task automatic send_random_frame();
    int labels;
    int len;
    if ($urandom_range(0, 5) == 0) wait_drained();
    send_item(OP_START, CH_W'($urandom_range(0, 255)), ID_W'($urandom), $urandom,
              ($urandom_range(0, 2) == 0));
    labels = $urandom_range(0, 4);
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      repeat (len) send_item(OP_CHAR, pick_char());
      if (l != labels - 1 || $urandom_range(0, 7) == 0) send_item(OP_CHAR, CH_DOT);
      if ($urandom_range(0, 15) == 0) send_item(OP_RSVD, CH_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 11) != 0) send_item(OP_END);
  endtask

  // Stray items between frames that the framer must ignore.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_item(OP_CHAR, CH_W'($urandom_range(0, 255)));
      1:       send_item(OP_END, CH_W'($urandom_range(0, 255)), ID_W'($urandom), $urandom,
                         1'($urandom_range(0, 1)));
      default: send_item(OP_RSVD, CH_W'($urandom_range(0, 255)), ID_W'($urandom), $urandom,
                         1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic test_random_frames(int target);
    int stop_at;
    stop_at = useful_items + target;
    while (useful_items < stop_at) begin
      if (frame_open == 1'b0 && $urandom_range(0, 4) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  // Result side: random stall bursts while enabled, otherwise always ready.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_stall_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic compare_field(string name, logic [7:0] expv, logic [7:0] gotv);
    if (expv !== gotv) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, gotv);
    end
  endtask

  // Every accepted result is checked against the oldest owed pair.
  always @(posedge clk) begin : result_check
    frame_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pairs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = pairs_due.pop_front();
        compare_field("byte_first", want.first_b, out_tdata[7:0]);
        compare_field("byte_second", want.second_b, out_tdata[15:8]);
        compare_field("byte_count", 8'(want.count), 8'(out_tdata[17:16]));
        compare_field("run_last", 8'(want.run_last), 8'(out_tuser[0]));
        compare_field("frame_last", 8'(want.frame_last), 8'(out_tlast));
        compare_field("frame_error", 8'(want.frame_error), 8'(out_tuser[1]));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    errors        = 0;
    useful_items  = 0;
    tx_idle_on    = 1'b1;
    rx_stall_on   = 1'b1;
    label_len     = '0;
    label_overrun = 1'b0;
    resp_id       = '0;
    resp_ip       = '0;
    resp_no_ans   = 1'b0;
    frame_open    = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_START;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_outside_frame();
    test_header_extremes();
    test_label_forms();
    test_restart_in_frame();
    test_overlong_label();

    // Random frames: idle, then a stretch with no idling, idle again,
    // and a final part with neither side idling.
    test_random_frames(50);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    test_random_frames(40);
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_random_frames(50);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    test_random_frames(40);

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
